[src/dwpi_pkg.sv]
// Package for the dual wheel PI controller with ramp profile.
// Holds payload structs, state and profile codes, and the profile table and functions.
// No dependencies.
`default_nettype none
package dwpi_pkg;

   localparam int FIFO_DEPTH_DEF     = 512;
   localparam int INTEGRAL_WIDTH_DEF = 32;
   localparam int CSR_INDEX_W        = 3;
   localparam int CSR_DATA_W         = 16;

   localparam logic [15:0] GAIN_P_RESET = 16'd6000;
   localparam logic [15:0] GAIN_I_RESET = 16'd10000;
   localparam logic [7:0]  PERIOD_RESET = 8'd10;
   localparam logic [15:0] DELAY_RESET  = 16'd50;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN_P_RIGHT = 3'd0,
      CSR_GAIN_I_RIGHT = 3'd1,
      CSR_GAIN_P_LEFT  = 3'd2,
      CSR_GAIN_I_LEFT  = 3'd3,
      CSR_DRIVE_ENABLE = 3'd4,
      CSR_SP_PERIOD    = 3'd5,
      CSR_START_DELAY  = 3'd6
   } csr_index_type;

   typedef enum logic [0:0] {OP_TICK = 1'b0, OP_MOVE = 1'b1} opcode_type;

   typedef enum logic [1:0] {MT_STRAIGHT = 2'd0, MT_TURN = 2'd1, MT_SHORT = 2'd2}
      move_type_type;

   typedef enum logic [2:0] {
      DIR_NONE = 3'd0, DIR_FORWARD = 3'd1, DIR_BACK = 3'd2, DIR_LEFT = 3'd3, DIR_RIGHT = 3'd4
   } dir_type;

   typedef enum logic [1:0] {PK_STRAIGHT = 2'd0, PK_TURN = 2'd1, PK_SHORT = 2'd2}
      prof_kind_type;

   typedef enum logic [2:0] {
      S_IDLE, S_PUSH, S_READ, S_CALC, S_PIWAIT, S_FINISH
   } state_type;

   typedef struct packed {
      logic              opcode;
      logic [15:0]       right_count;
      logic [15:0]       left_count;
      logic [1:0]        move_type;
      logic signed [7:0] move_distance;
   } req_type;

   typedef struct packed {
      logic [15:0]       drive_right;
      logic [15:0]       drive_left;
      logic              drive_updated;
      logic [2:0]        direction_code;
      logic              move_done;
      logic [1:0]        done_type;
      logic signed [7:0] done_distance;
      logic              fifo_overflow;
   } rsp_type;

   typedef struct packed {
      logic          start;
      prof_kind_type kind;
      logic          pop;
   } fifo_ctrl_type;

   typedef struct packed {
      logic       busy;
      logic       empty;
      logic       overflow;
      logic [7:0] rdata;
   } fifo_stat_type;

   typedef logic [7:0] short_tab_type [12];
   localparam short_tab_type SHORT_PROFILE = '{
      8'd0, 8'd2, 8'd2, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd2, 8'd2, 8'd0
   };

   function automatic logic [4:0] profile_len(prof_kind_type kind);
      logic [4:0] len;
      unique case (kind)
         PK_STRAIGHT: len = 5'd18;
         PK_TURN:     len = 5'd27;
         PK_SHORT:    len = 5'd12;
         default:     len = 5'd1;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] profile_value(prof_kind_type kind, logic [4:0] idx);
      logic [4:0] v;
      v = 5'd0;
      unique case (kind)
         PK_STRAIGHT: begin
            if (idx < 5'd6) v = idx;
            else if (idx < 5'd12) v = 5'd5;
            else v = 5'd17 - idx;
         end
         PK_TURN: begin
            if (idx < 5'd10) v = idx >> 1;
            else if (idx < 5'd17) v = 5'd4;
            else v = (5'd26 - idx) >> 1;
         end
         PK_SHORT: begin
            if (idx < 5'd12) v = SHORT_PROFILE[idx[3:0]][4:0];
         end
         default: v = 5'd0;
      endcase
      return {3'd0, v};
   endfunction

endpackage
`default_nettype wire

[src/dwpi_profile_fifo.sv]
// Setpoint FIFO and ramp generator, filling one entry per cycle when not
// full; entries that find it full are dropped. Depends on dwpi_pkg.
`default_nettype none
module dwpi_profile_fifo import dwpi_pkg::*; #(
   parameter int DEPTH = FIFO_DEPTH_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire fifo_ctrl_type ctrl,
   output fifo_stat_type stat
);
   localparam int AW = $clog2(DEPTH);

   logic [7:0] mem [DEPTH];
   logic [AW-1:0] head_ff, head_in;
   logic [AW:0]   fill_ff, fill_in;
   logic          busy_ff, busy_in;
   prof_kind_type kind_ff, kind_in;
   logic [4:0]    idx_ff, idx_in;
   logic          ovf_ff, ovf_in;
   logic [7:0]    rdata_ff;

   logic [AW:0] sum, pos;
   logic        full, push, drop;

   always_comb begin
      sum  = (AW+1)'(head_ff) + fill_ff;
      pos  = (sum >= (AW+1)'(DEPTH)) ? sum - (AW+1)'(DEPTH) : sum;
      full = (fill_ff == (AW+1)'(DEPTH));
      push = busy_ff && !full;
      drop = busy_ff && full;
   end

   always_comb begin
      busy_in = busy_ff;
      kind_in = kind_ff;
      idx_in  = idx_ff;
      ovf_in  = ovf_ff;
      head_in = head_ff;
      fill_in = fill_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         kind_in = ctrl.kind;
         idx_in  = 5'd0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         idx_in = idx_ff + 5'd1;
         if (drop) ovf_in = 1'b1;
         if (idx_ff == profile_len(kind_ff) - 5'd1) busy_in = 1'b0;
      end
      if (push) fill_in = fill_ff + (AW+1)'(1);
      if (ctrl.pop) begin
         fill_in = fill_ff - (AW+1)'(1);
         head_in = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         kind_ff <= PK_STRAIGHT;
         idx_ff  <= 5'd0;
         ovf_ff  <= 1'b0;
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         kind_ff <= kind_in;
         idx_ff  <= idx_in;
         ovf_ff  <= ovf_in;
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[pos[AW-1:0]] <= profile_value(kind_ff, idx_ff);
      if (ctrl.pop) rdata_ff <= mem[head_ff];
   end

   assign stat.busy     = busy_ff;
   assign stat.empty    = (fill_ff == '0);
   assign stat.overflow = ovf_ff;
   assign stat.rdata    = rdata_ff;

endmodule
`default_nettype wire

[src/dwpi_pi_wheel.sv]
// One wheel's PI loop: saturating integral and a bit-serial shift-add
// product of both gains, one gain bit per cycle. Depends on dwpi_pkg.
`default_nettype none
module dwpi_pi_wheel import dwpi_pkg::*; #(
   parameter int IW = INTEGRAL_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [7:0]  target,
   input  wire logic [15:0] count,
   input  wire logic [15:0] kp,
   input  wire logic [15:0] ki,
   output logic             busy,
   output logic [15:0]      drive
);
   localparam int ICW   = 36;
   localparam int XW    = (IW > ICW) ? IW : ICW;
   localparam int ACC_W = 54;
   localparam logic signed [IW:0] IMAX = (IW+1)'((64'sd1 <<< (IW - 1)) - 64'sd1);
   localparam logic signed [IW:0] IMIN = -IMAX - (IW+1)'(1);
   localparam logic signed [XW-1:0] LIM = XW'(64'sd17179869184);

   logic signed [IW-1:0]    integ_ff, integ_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in, mcand_ff, mcand_in;
   logic [15:0]             gsh_ff, gsh_in;
   logic [5:0]              cnt_ff, cnt_in;
   logic                    busy_ff, busy_in;
   logic [15:0]             drive_ff, drive_in;

   logic signed [16:0]   err;
   logic signed [IW:0]   isum;
   logic signed [XW-1:0] ix, icl;
   logic signed [ICW-1:0] ic;

   always_comb begin
      err  = signed'({9'd0, target}) - signed'({1'b0, count});
      isum = (IW+1)'(integ_ff) + (IW+1)'(err);
      ix   = XW'(integ_ff);
      if (ix > LIM) icl = LIM;
      else if (ix < -LIM) icl = -LIM;
      else icl = ix;
      ic = ICW'(icl);
   end

   always_comb begin
      integ_in = integ_ff;
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      gsh_in   = gsh_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      drive_in = drive_ff;
      if (start) begin
         if (isum > IMAX) integ_in = IW'(IMAX);
         else if (isum < IMIN) integ_in = IW'(IMIN);
         else integ_in = IW'(isum);
         acc_in   = '0;
         mcand_in = ACC_W'(err);
         gsh_in   = kp;
         cnt_in   = 6'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == 6'd32) begin
            busy_in = 1'b0;
            if (acc_ff <= 0) drive_in = 16'd0;
            else if (acc_ff > ACC_W'(65535)) drive_in = 16'hFFFF;
            else drive_in = acc_ff[15:0];
         end else begin
            if (gsh_ff[0]) acc_in = acc_ff + mcand_ff;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd15) begin
               mcand_in = ACC_W'(ic);
               gsh_in   = ki;
            end else begin
               mcand_in = mcand_ff <<< 1;
               gsh_in   = gsh_ff >> 1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
         busy_ff  <= 1'b0;
         cnt_ff   <= 6'd0;
         drive_ff <= 16'd0;
      end else begin
         integ_ff <= integ_in;
         busy_ff  <= busy_in;
         cnt_ff   <= cnt_in;
         drive_ff <= drive_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      gsh_ff   <= gsh_in;
   end

   assign busy  = busy_ff;
   assign drive = drive_ff;

endmodule
`default_nettype wire

[src/dual_wheel_pi_with_ramp_profile_unit.sv]
// Top level: request sequencer, config registers, setpoint FIFO and two
// bit-serial PI wheels. Depends on dwpi_pkg, dwpi_profile_fifo, dwpi_pi_wheel.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_payload (req_type)
//   rsp      out        rsp_valid/rsp_ready    rsp_payload (rsp_type)
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// A tick that runs the PI loop waits in S_PIWAIT on the 32-step
// shift-add product in each wheel; a tick without it skips that state.
// A move command fills the FIFO one profile entry per cycle, up to 27.
// Reset is synchronous; the FIFO contents are not cleared and need no sweep.
// A new request is taken while the last response still waits on rsp_ready.
`default_nettype none
module dual_wheel_pi_with_ramp_profile_unit import dwpi_pkg::*; #(
   parameter int FIFO_DEPTH     = FIFO_DEPTH_DEF,
   parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire req_type                req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsp_type                     rsp_payload,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);
   logic [15:0] kp_r_ff, ki_r_ff, kp_l_ff, ki_l_ff, delay_ff, elapsed_ff, elapsed_in;
   logic        enable_ff;
   logic [7:0]  period_ff, phase_ff, phase_in, target_ff, target_in;
   logic [1:0]  ctype_ff, ctype_in;
   logic signed [7:0] cdist_ff, cdist_in;
   state_type   state_ff, state_in;
   rsp_type     build_ff, build_in, out_ff, out_in;
   logic        out_valid_ff, out_valid_in;
   logic [15:0] rc_ff, lc_ff;
   logic        popped_ff, popped_in, run_ff, run_in;

   fifo_ctrl_type fctrl;
   fifo_stat_type fstat;
   logic          pi_start, busy_r, busy_l;
   logic [15:0]   drv_r, drv_l;
   logic          accept, pushes;
   prof_kind_type kind;
   logic [8:0]    period_eff;

   dwpi_profile_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
      .clock(clock), .reset(reset), .ctrl(fctrl), .stat(fstat)
   );

   dwpi_pi_wheel #(.IW(INTEGRAL_WIDTH)) u_right (
      .clock(clock), .reset(reset), .start(pi_start), .target(target_ff),
      .count(rc_ff), .kp(kp_r_ff), .ki(ki_r_ff), .busy(busy_r), .drive(drv_r)
   );

   dwpi_pi_wheel #(.IW(INTEGRAL_WIDTH)) u_left (
      .clock(clock), .reset(reset), .start(pi_start), .target(target_ff),
      .count(lc_ff), .kp(kp_l_ff), .ki(ki_l_ff), .busy(busy_l), .drive(drv_l)
   );

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_r_ff   <= GAIN_P_RESET;
         ki_r_ff   <= GAIN_I_RESET;
         kp_l_ff   <= GAIN_P_RESET;
         ki_l_ff   <= GAIN_I_RESET;
         enable_ff <= 1'b0;
         period_ff <= PERIOD_RESET;
         delay_ff  <= DELAY_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GAIN_P_RIGHT: kp_r_ff   <= csr_data;
            CSR_GAIN_I_RIGHT: ki_r_ff   <= csr_data;
            CSR_GAIN_P_LEFT:  kp_l_ff   <= csr_data;
            CSR_GAIN_I_LEFT:  ki_l_ff   <= csr_data;
            CSR_DRIVE_ENABLE: enable_ff <= csr_data[0];
            CSR_SP_PERIOD:    period_ff <= csr_data[7:0];
            CSR_START_DELAY:  delay_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      kind   = PK_SHORT;
      pushes = 1'b0;
      if (req_payload.move_type == MT_STRAIGHT &&
          (req_payload.move_distance == 8'sd3 || req_payload.move_distance == -8'sd3)) begin
         kind   = PK_STRAIGHT;
         pushes = 1'b1;
      end else if (req_payload.move_type == MT_TURN &&
          (req_payload.move_distance == 8'sd90 || req_payload.move_distance == -8'sd90)) begin
         kind   = PK_TURN;
         pushes = 1'b1;
      end else if (req_payload.move_type == MT_SHORT) begin
         pushes = 1'b1;
      end
      period_eff = (period_ff == 8'd0) ? 9'd1 : {1'b0, period_ff};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_payload.opcode == OP_MOVE) state_in = pushes ? S_PUSH : S_FINISH;
               else state_in = S_READ;
            end
         end
         S_PUSH:   if (!fstat.busy) state_in = S_FINISH;
         S_READ:   state_in = S_CALC;
         S_CALC:   state_in = run_ff ? S_PIWAIT : S_FINISH;
         S_PIWAIT: if (!busy_r && !busy_l) state_in = S_FINISH;
         S_FINISH: if (!out_valid_ff || rsp_ready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      req_ready    = (state_ff == S_IDLE);
      fctrl.start  = 1'b0;
      fctrl.kind   = kind;
      fctrl.pop    = 1'b0;
      pi_start     = 1'b0;
      build_in     = build_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      phase_in     = phase_ff;
      elapsed_in   = elapsed_ff;
      target_in    = target_ff;
      ctype_in     = ctype_ff;
      cdist_in     = cdist_ff;
      popped_in    = popped_ff;
      run_in       = run_ff;
      if (out_valid_ff && rsp_ready) out_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               build_in = '0;
               if (req_payload.opcode == OP_MOVE) begin
                  ctype_in    = req_payload.move_type;
                  cdist_in    = req_payload.move_distance;
                  fctrl.start = pushes;
                  if (kind == PK_STRAIGHT && pushes)
                     build_in.direction_code = (req_payload.move_distance > 0) ?
                                               DIR_FORWARD : DIR_BACK;
                  else if (kind == PK_TURN)
                     build_in.direction_code = (req_payload.move_distance > 0) ?
                                               DIR_LEFT : DIR_RIGHT;
               end else begin
                  popped_in = 1'b0;
                  if (phase_ff == 8'd0) begin
                     if (!fstat.empty) begin
                        fctrl.pop = 1'b1;
                        popped_in = 1'b1;
                     end else begin
                        build_in.move_done     = 1'b1;
                        build_in.done_type     = ctype_ff;
                        build_in.done_distance = cdist_ff;
                        cdist_in               = 8'sd0;
                     end
                  end
                  phase_in = ({1'b0, phase_ff} + 9'd1 >= period_eff) ? 8'd0 : phase_ff + 8'd1;
                  run_in   = (elapsed_ff >= delay_ff) && enable_ff;
                  build_in.drive_updated = (elapsed_ff >= delay_ff) && enable_ff;
                  if (elapsed_ff < delay_ff) elapsed_in = elapsed_ff + 16'd1;
               end
            end
         end
         S_PUSH: if (!fstat.busy) build_in.fifo_overflow = fstat.overflow;
         S_READ: if (popped_ff) target_in = fstat.rdata;
         S_CALC: pi_start = run_ff;
         S_PIWAIT: ;
         S_FINISH: begin
            if (!out_valid_ff || rsp_ready) begin
               out_in             = build_ff;
               out_in.drive_right = drv_r;
               out_in.drive_left  = drv_l;
               out_valid_in       = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         phase_ff     <= 8'd0;
         elapsed_ff   <= 16'd0;
         target_ff    <= 8'd0;
         ctype_ff     <= 2'd0;
         cdist_ff     <= 8'sd0;
         popped_ff    <= 1'b0;
         run_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         elapsed_ff   <= elapsed_in;
         target_ff    <= target_in;
         ctype_ff     <= ctype_in;
         cdist_ff     <= cdist_in;
         popped_ff    <= popped_in;
         run_ff       <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      build_ff <= build_in;
      out_ff   <= out_in;
      if (accept) begin
         rc_ff <= req_payload.right_count;
         lc_ff <= req_payload.left_count;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready) else $error("request taken while busy");
   a_pi_in_wait: assert property (@(posedge clock) disable iff (reset)
      (busy_r || busy_l) |-> state_ff == S_PIWAIT) else $error("PI runs outside wait");
   a_gen_in_push: assert property (@(posedge clock) disable iff (reset)
      fstat.busy |-> state_ff == S_PUSH) else $error("profile fill outside push");
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_FINISH)) else $error("stray response");

endmodule
`default_nettype wire
